### src/peer_wire_deframer_core_defines.svh
// Assertion macros used by the deframer parser.
`ifndef PEER_WIRE_DEFRAMER_CORE_DEFINES_SVH
`define PEER_WIRE_DEFRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is high.
`define PWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds while reset is high.
`define PWD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PWD_ASSERT(label, clk, rst, prop, msg)
`define PWD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### src/pwd_pkg.sv
// Types, codes and constants shared by the peer-wire deframer modules.
package pwd_pkg;

   localparam int CNT_W     = 5;
   localparam int MAGIC_LEN = 18;
   localparam int PAD_LEN   = 10;
   localparam int WORD_LEN  = 4;

   localparam logic [CNT_W-1:0] MAGIC_LAST = CNT_W'(MAGIC_LEN - 1);
   localparam logic [CNT_W-1:0] PAD_LAST   = CNT_W'(PAD_LEN - 1);
   localparam logic [CNT_W-1:0] WORD_LAST  = CNT_W'(WORD_LEN - 1);

   localparam logic [1:0] KIND_HANDSHAKE = 2'd0;
   localparam logic [1:0] KIND_HEADER    = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD   = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   localparam logic [1:0] ERR_BAD_MAGIC  = 2'd0;
   localparam logic [1:0] ERR_BAD_PAD    = 2'd1;
   localparam logic [1:0] ERR_ID_MISMATCH = 2'd2;
   localparam logic [1:0] ERR_ZERO_LEN   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [31:0] plen;
      logic [1:0]  code;
      logic        last;
   } pwd_event_type;

   // Handshake magic text, one character per position.
   function automatic logic [7:0] magic_char(input logic [CNT_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:    c = 8'h50; // P
         5'd1:    c = 8'h32; // 2
         5'd2:    c = 8'h50; // P
         5'd3:    c = 8'h46; // F
         5'd4:    c = 8'h49; // I
         5'd5:    c = 8'h4C; // L
         5'd6:    c = 8'h45; // E
         5'd7:    c = 8'h53; // S
         5'd8:    c = 8'h48; // H
         5'd9:    c = 8'h41; // A
         5'd10:   c = 8'h52; // R
         5'd11:   c = 8'h49; // I
         5'd12:   c = 8'h4E; // N
         5'd13:   c = 8'h47; // G
         5'd14:   c = 8'h50; // P
         5'd15:   c = 8'h52; // R
         5'd16:   c = 8'h4F; // O
         5'd17:   c = 8'h4A; // J
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### src/pwd_parser.sv
// Byte-serial parser: handshake check, message framing and event generation.
`include "peer_wire_deframer_core_defines.svh"

module pwd_parser
   import pwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    rx_byte,
   input  logic [31:0]   expected_id,
   input  logic          check_id,
   output logic          ev_valid,
   output pwd_event_type ev
);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_PAD,
      PH_ID,
      PH_LEN,
      PH_TYPE,
      PH_PAYLOAD,
      PH_DEAD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              bad_ff, bad_in;
   logic [31:0]       shift_ff, shift_in;
   logic [31:0]       remaining_ff, remaining_in;

   logic [31:0] shift_cat;
   logic [31:0] rem_dec;
   logic        magic_bad;
   logic        pad_bad;

   logic        is_dead;
   logic        err_taken;
   logic        payload_empty;
   logic        stray_plen;

   assign shift_cat = {shift_ff[23:0], rx_byte};
   assign rem_dec   = remaining_ff - 32'd1;
   assign magic_bad = bad_ff | (rx_byte != magic_char(cnt_ff));
   assign pad_bad   = bad_ff | (rx_byte != 8'h00);

   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      shift_in     = shift_ff;
      remaining_in = remaining_ff;
      ev_valid     = 1'b0;
      ev           = '{kind: KIND_ERROR, value: 32'd0, plen: 32'd0,
                       code: ERR_BAD_MAGIC, last: 1'b0};
      case (phase_ff)
         PH_MAGIC: begin
            bad_in = magic_bad;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MAGIC_LAST) begin
               cnt_in = '0;
               if (magic_bad) begin
                  phase_in = PH_DEAD;
                  ev_valid = 1'b1;
                  ev.code  = ERR_BAD_MAGIC;
               end else begin
                  phase_in = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            bad_in = pad_bad;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == PAD_LAST) begin
               cnt_in = '0;
               if (pad_bad) begin
                  phase_in = PH_DEAD;
                  ev_valid = 1'b1;
                  ev.code  = ERR_BAD_PAD;
               end else begin
                  phase_in = PH_ID;
                  shift_in = '0;
               end
            end
         end
         PH_ID: begin
            shift_in = shift_cat;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST) begin
               cnt_in   = '0;
               ev_valid = 1'b1;
               if (check_id && (shift_cat != expected_id)) begin
                  phase_in = PH_DEAD;
                  ev.code  = ERR_ID_MISMATCH;
               end else begin
                  phase_in = PH_LEN;
                  shift_in = '0;
                  ev.kind  = KIND_HANDSHAKE;
                  ev.value = shift_cat;
               end
            end
         end
         PH_LEN: begin
            shift_in = shift_cat;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == WORD_LAST) begin
               cnt_in = '0;
               if (shift_cat == 32'd0) begin
                  phase_in = PH_DEAD;
                  ev_valid = 1'b1;
                  ev.code  = ERR_ZERO_LEN;
               end else begin
                  phase_in     = PH_TYPE;
                  shift_in     = '0;
                  remaining_in = shift_cat - 32'd1;
               end
            end
         end
         PH_TYPE: begin
            phase_in = (remaining_ff != 32'd0) ? PH_PAYLOAD : PH_LEN;
            ev_valid = 1'b1;
            ev.kind  = KIND_HEADER;
            ev.value = {24'd0, rx_byte};
            ev.plen  = remaining_ff;
            ev.last  = (remaining_ff == 32'd0);
         end
         PH_PAYLOAD: begin
            remaining_in = rem_dec;
            if (rem_dec == 32'd0) begin
               phase_in = PH_LEN;
            end
            ev_valid = 1'b1;
            ev.kind  = KIND_PAYLOAD;
            ev.value = {24'd0, rx_byte};
            ev.last  = (rem_dec == 32'd0);
         end
         default: begin
            // Dead after an error: every byte is dropped until reset.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         cnt_ff       <= '0;
         bad_ff       <= 1'b0;
         shift_ff     <= '0;
         remaining_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         bad_ff       <= bad_in;
         shift_ff     <= shift_in;
         remaining_ff <= remaining_in;
      end
   end

   assign is_dead       = (phase_ff == PH_DEAD);
   assign err_taken     = step && ev_valid && (ev.kind == KIND_ERROR);
   assign payload_empty = (phase_ff == PH_PAYLOAD) && (remaining_ff == 32'd0);
   assign stray_plen    = ev_valid && (ev.kind != KIND_HEADER) && (ev.plen != 32'd0);

   `PWD_ASSERT(a_dead_is_silent, clock, reset, is_dead |-> !ev_valid, "event while dead")
   `PWD_ASSERT(a_error_kills, clock, reset, err_taken |=> is_dead, "parser alive after an error")
   `PWD_ASSERT(a_payload_nonempty, clock, reset, !payload_empty, "payload phase with no bytes left")
   `PWD_ASSERT(a_plen_only_header, clock, reset, !stray_plen, "length on a non-header event")

endmodule

### src/pwd_out_reg.sv
// Result register between the parser and the result channel.
module pwd_out_reg
   import pwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  pwd_event_type load_ev,
   output logic          in_ready,
   input  logic          out_ready,
   output logic          out_valid,
   output pwd_event_type out_ev
);

   logic          valid_ff;
   pwd_event_type ev_ff;

   // A new item may enter while the held result is taken in the same cycle.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_ev    = ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && load) begin
         ev_ff <= load_ev;
      end
   end

endmodule

### src/peer_wire_deframer_core.sv
// Top level of the peer-wire deframer: ports, configuration registers and wiring.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_tvalid/req_tready  tdata: received byte
//   rsp      out        rsp_tvalid/rsp_tready  tdata/tuser/tlast: one event
//   csr      in         csr_valid/csr_ready    register index and data
//
// A byte's event, if any, appears in the result register in the cycle after the
// byte is taken, so one byte per cycle is sustained while rsp_tready stays high.
// The parser state updates in a single pass per byte; the result register is the
// only storage between the two channels.
// Synchronous active-high reset clears the parser, CSRs and result valid flag.
// A stalled result channel holds req_tready low only while a result is waiting.
module peer_wire_deframer_core
   import pwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] event_value, [63:32] payload count,
                                    // [65:64] error_code, [71:66] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast,   // last_of_message
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam logic REG_EXPECTED_ID = 1'b0;
   localparam logic REG_CHECK_ID    = 1'b1;

   logic [31:0]   expected_id_ff;
   logic          check_id_ff;
   logic          step;
   logic          ev_valid;
   pwd_event_type ev;
   pwd_event_type out_ev;

   assign csr_ready = 1'b1;
   assign step      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
         check_id_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_EXPECTED_ID: expected_id_ff <= csr_data;
            REG_CHECK_ID:    check_id_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   pwd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_tdata),
      .expected_id (expected_id_ff),
      .check_id    (check_id_ff),
      .ev_valid    (ev_valid),
      .ev          (ev)
   );

   pwd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && ev_valid),
      .load_ev   (ev),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_ev    (out_ev)
   );

   assign rsp_tdata = {6'd0, out_ev.code, out_ev.plen, out_ev.value};
   assign rsp_tuser = out_ev.kind;
   assign rsp_tlast = out_ev.last;

endmodule

### dv/pwd_tb_pkg.sv
// Register indexes and handshake text shared by the deframer testbench files.
package pwd_tb_pkg;

   localparam logic CSR_EXPECTED_ID = 1'b0;
   localparam logic CSR_CHECK_ID    = 1'b1;

   // Handshake magic, first character in the highest byte.
   localparam logic [8*18-1:0] HS_TEXT = "P2PFILESHARINGPROJ";

endpackage

### dv/pwd_event_checker.sv
// Checker that predicts deframer events from the observed channels and compares them.
module pwd_event_checker
   import pwd_pkg::*;
   import pwd_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          pending_events,
   output int          mismatch_count
);

   typedef enum logic [2:0] {
      RX_MAGIC, RX_PAD, RX_ID, RX_LEN, RX_TYPE, RX_PAYLOAD, RX_DEAD
   } rx_phase_type;

   rx_phase_type     rx_phase;
   logic [CNT_W-1:0] rx_count;
   logic             hs_bad;
   logic [31:0]      word_shift;
   logic [31:0]      payload_left;
   logic [31:0]      cfg_peer_id;
   logic             cfg_check_id;

   pwd_event_type expected_events[$];

   function automatic void raise_error(input logic [1:0] code, output pwd_event_type ev);
      rx_phase = RX_DEAD;
      ev       = '0;
      ev.kind  = KIND_ERROR;
      ev.code  = code;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields an event.
   function automatic bit predict_event(input logic [7:0] b, output pwd_event_type ev);
      bit emits;
      emits = 1'b0;
      ev    = '0;
      case (rx_phase)
         RX_MAGIC: begin
            if (b != HS_TEXT[8*(MAGIC_LEN-1-int'(rx_count)) +: 8]) hs_bad = 1'b1;
            rx_count = rx_count + 1'b1;
            if (rx_count >= CNT_W'(MAGIC_LEN)) begin
               if (hs_bad) begin
                  raise_error(ERR_BAD_MAGIC, ev);
                  emits = 1'b1;
               end else begin
                  rx_phase = RX_PAD;
                  rx_count = '0;
               end
            end
         end
         RX_PAD: begin
            if (b != 8'h00) hs_bad = 1'b1;
            rx_count = rx_count + 1'b1;
            if (rx_count >= CNT_W'(PAD_LEN)) begin
               if (hs_bad) begin
                  raise_error(ERR_BAD_PAD, ev);
                  emits = 1'b1;
               end else begin
                  rx_phase   = RX_ID;
                  rx_count   = '0;
                  word_shift = '0;
               end
            end
         end
         RX_ID: begin
            word_shift = {word_shift[23:0], b};
            rx_count   = rx_count + 1'b1;
            if (rx_count >= CNT_W'(WORD_LEN)) begin
               emits = 1'b1;
               if (cfg_check_id && word_shift != cfg_peer_id) begin
                  raise_error(ERR_ID_MISMATCH, ev);
               end else begin
                  rx_phase   = RX_LEN;
                  rx_count   = '0;
                  ev.kind    = KIND_HANDSHAKE;
                  ev.value   = word_shift;
                  word_shift = '0;
               end
            end
         end
         RX_LEN: begin
            word_shift = {word_shift[23:0], b};
            rx_count   = rx_count + 1'b1;
            if (rx_count >= CNT_W'(WORD_LEN)) begin
               if (word_shift == '0) begin
                  raise_error(ERR_ZERO_LEN, ev);
                  emits = 1'b1;
               end else begin
                  payload_left = word_shift - 32'd1;
                  word_shift   = '0;
                  rx_count     = '0;
                  rx_phase     = RX_TYPE;
               end
            end
         end
         RX_TYPE: begin
            rx_phase = (payload_left != '0) ? RX_PAYLOAD : RX_LEN;
            ev.kind  = KIND_HEADER;
            ev.value = {24'h0, b};
            ev.plen  = payload_left;
            ev.last  = (payload_left == '0);
            emits    = 1'b1;
         end
         RX_PAYLOAD: begin
            payload_left = payload_left - 32'd1;
            if (payload_left == '0) rx_phase = RX_LEN;
            ev.kind  = KIND_PAYLOAD;
            ev.value = {24'h0, b};
            ev.last  = (payload_left == '0);
            emits    = 1'b1;
         end
         default: ;
      endcase
      return emits;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      pwd_event_type ev;
      if (reset) begin
         rx_phase     = RX_MAGIC;
         rx_count     = '0;
         hs_bad       = 1'b0;
         word_shift   = '0;
         payload_left = '0;
         cfg_peer_id  = '0;
         cfg_check_id = 1'b0;
         expected_events.delete();
      end else begin
         // Register writes take effect before a byte taken at the same edge.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPECTED_ID: cfg_peer_id  = csr_data;
               CSR_CHECK_ID:    cfg_check_id = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (predict_event(req_tdata, ev)) expected_events = {expected_events, ev};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("event_kind: expected none, actual %0d", rsp_tuser);
               mismatch_count++;
            end else begin
               ev = expected_events.pop_front();
               compare_field("event_kind", {30'h0, ev.kind}, {30'h0, rsp_tuser});
               compare_field("event_value", ev.value, rsp_tdata[31:0]);
               compare_field("payload_count", ev.plen, rsp_tdata[63:32]);
               compare_field("error_code", {30'h0, ev.code}, {30'h0, rsp_tdata[65:64]});
               compare_field("last_of_message", {31'h0, ev.last}, {31'h0, rsp_tlast});
               compare_field("tdata_fill", 32'h0, {26'h0, rsp_tdata[71:66]});
            end
         end
      end
      pending_events = expected_events.size();
   end

endmodule

### dv/tb_peer_wire_deframer_core.sv
// Testbench top for the peer-wire deframer: clock, reset, stimulus and verdict.
module tb_peer_wire_deframer_core
   import pwd_pkg::*;
   import pwd_tb_pkg::*;
();

   localparam int ITEM_TARGET  = 700;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic        csr_index  = 1'b0;
   logic [31:0] csr_data   = 32'h0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_ready;

   int pending_events;
   int mismatch_count;
   int cycle_count   = 0;
   int bytes_sent    = 0;
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   bit hold_request    = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   peer_wire_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pwd_event_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pending_events (pending_events),
      .mismatch_count (mismatch_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("peer_wire_deframer_core test failed");
         $finish;
      end
   end

   // Result side: random or no stall before each item, with one long hold-off.
   initial begin : receiver
      int stall;
      int served;
      bit hold_done;
      served    = 0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         if (served % 40 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
         stall = receiver_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
      end
   end

   // The valid line stays high between items that follow without a gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
   endtask

   task automatic send_frame(input int len, input logic [7:0] msg_type);
      send_word(len);
      send_byte(msg_type);
      for (int i = 1; i < len; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Length bytes yield no event, so the drain waits on past the last expected event.
   task automatic drain_events();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_events != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] peer_id, input logic check_id);
      csr_valid <= 1'b1;
      csr_index <= CSR_EXPECTED_ID;
      csr_data  <= peer_id;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_CHECK_ID;
      csr_data  <= {31'h0, check_id};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_peer_id();
      case ($urandom_range(0, 2))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] peer_id;
      int          msg_count;
      int          len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      peer_id = $urandom;
      write_regs(peer_id, 1'b1);

      for (int i = 0; i < MAGIC_LEN; i++) send_byte(HS_TEXT[8*(MAGIC_LEN-1-i) +: 8]);
      for (int i = 0; i < PAD_LEN; i++) send_byte(8'h00);
      send_word(peer_id);

      // Headers with an empty payload, then short payloads at the byte extremes.
      send_frame(1, 8'h00);
      send_frame(1, 8'hFF);
      send_word(32'd2);
      send_byte(8'h55);
      send_byte(8'hFF);
      send_word(32'd3);
      send_byte(8'hAA);
      send_byte(8'h00);
      send_byte(8'hFF);

      drain_events();
      write_regs(32'hFFFF_FFFF, 1'b0);

      msg_count = 0;
      while (bytes_sent < ITEM_TARGET) begin
         msg_count++;
         if (msg_count % 8 == 0) sender_steady = ($urandom_range(0, 2) == 0);
         if (msg_count == 5) hold_request = 1'b1;
         if (msg_count % 10 == 0) begin
            drain_events();
            write_regs(pick_peer_id(), 1'($urandom_range(0, 1)));
         end
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
         send_frame(len, 8'($urandom_range(0, 255)));
      end

      // The run ends either on a zero length, which kills the parser, or inside
      // a message of the largest length.
      sender_steady = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
         send_word(32'h0000_0000);
         for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_word(32'hFFFF_FFFF);
         send_byte(8'($urandom_range(0, 255)));
         for (int i = 0; i < 10; i++) send_byte(8'($urandom_range(0, 255)));
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_events != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("peer_wire_deframer_core test passed");
      end else begin
         $display("peer_wire_deframer_core test failed");
      end
      $finish;
   end

endmodule
